@@ rtl/ssa_pkg.sv @@
`default_nettype none

package ssa_pkg;

  // Field widths of the command and result transactions.
  localparam int unsigned CmdWidth     = 2;
  localparam int unsigned SlotWidth    = 3;
  localparam int unsigned WeightWidth  = 16;
  localparam int unsigned LoadWidth    = 16;
  localparam int unsigned RandomWidth  = 16;
  localparam int unsigned StratWidth   = 2;
  localparam int unsigned CounterWidth = 32;
  localparam int unsigned DefaultSlots = 8;

  // Command codes.
  localparam logic [CmdWidth-1:0] CmdSelect = 2'd0;
  localparam logic [CmdWidth-1:0] CmdWrite  = 2'd1;
  localparam logic [CmdWidth-1:0] CmdLoad   = 2'd2;

  // Strategy codes.
  localparam logic [StratWidth-1:0] StratRoundRobin = 2'd0;
  localparam logic [StratWidth-1:0] StratLeastLoad  = 2'd1;
  localparam logic [StratWidth-1:0] StratWeighted   = 2'd2;
  localparam logic [StratWidth-1:0] StratFirst      = 2'd3;

  // One slot of the server table; the present bit lives in flip-flops.
  typedef struct packed {
    logic                   active;
    logic [WeightWidth-1:0] weight;
    logic [LoadWidth-1:0]   load_limit;
    logic [LoadWidth-1:0]   load;
  } slot_entry_t;

  // Access controls toward the table.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic wr_present;
  } tbl_ctrl_t;

  // Status of the remainder unit.
  typedef struct packed {
    logic busy;
    logic done;
  } mod_status_t;

endpackage

`default_nettype wire

@@ rtl/ssa_table.sv @@
`default_nettype none

module ssa_table #(
  parameter int unsigned Slots     = ssa_pkg::DefaultSlots,
  parameter int unsigned AddrWidth = 3
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  ssa_pkg::tbl_ctrl_t   ctrl_i,
  input  wire  [AddrWidth-1:0] rd_addr_i,
  input  wire  [AddrWidth-1:0] wr_addr_i,
  input  ssa_pkg::slot_entry_t wr_data_i,
  output ssa_pkg::slot_entry_t rd_data_o,
  output logic                 rd_present_o
);

  ssa_pkg::slot_entry_t mem_q [Slots];
  logic [Slots-1:0]     valid_q;
  ssa_pkg::slot_entry_t rd_data_q;
  logic                 rd_present_q;

  // Present bits come out of reset cleared, so no sweep over the memory is needed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      rd_present_q <= 1'b0;
    end else begin
      if (ctrl_i.wr_en) begin
        valid_q[wr_addr_i] <= ctrl_i.wr_present;
      end
      if (ctrl_i.rd_en) begin
        rd_present_q <= valid_q[rd_addr_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (ctrl_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  // A slot that is not present reads as all zero.
  assign rd_data_o    = rd_present_q ? rd_data_q : '0;
  assign rd_present_o = rd_present_q;

endmodule

`default_nettype wire

@@ rtl/ssa_mod_unit.sv @@
`default_nettype none

module ssa_mod_unit #(
  parameter int unsigned DivisorWidth = 4
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  start_i,
  input  wire  [ssa_pkg::CounterWidth-1:0]     dividend_i,
  input  wire  [DivisorWidth-1:0]              divisor_i,
  output ssa_pkg::mod_status_t                 status_o,
  output logic [DivisorWidth-1:0]              rem_o
);

  localparam int unsigned DvdWidth  = ssa_pkg::CounterWidth;
  localparam int unsigned StepWidth = $clog2(DvdWidth);

  logic                    busy_q;
  logic                    done_q;
  logic [StepWidth-1:0]    step_q;
  logic [DvdWidth-1:0]     dvd_q;
  logic [DivisorWidth-1:0] dvs_q;
  logic [DivisorWidth-1:0] rem_q;
  logic [DivisorWidth:0]   shifted;
  logic [DivisorWidth:0]   diff;
  logic [DivisorWidth-1:0] rem_d;

  // Restoring remainder, one dividend bit per cycle, most significant first.
  assign shifted = {rem_q, dvd_q[DvdWidth-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign rem_d   = (shifted >= {1'b0, dvs_q}) ? diff[DivisorWidth-1:0]
                                              : shifted[DivisorWidth-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == StepWidth'(DvdWidth - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DvdWidth-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign rem_o         = rem_q;

`ifndef SYNTHESIS
  // The remainder handed out must already be reduced below the divisor.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> rem_q < dvs_q)
    else $error("remainder not below divisor at completion");
`endif

endmodule

`default_nettype wire

@@ rtl/server_selection_arbiter_core.sv @@
// Server selection arbiter.
// Input channel (in_valid_i / in_ready_o) carries one command transaction: select,
// write a slot entry, or set a slot's load. Every command yields exactly one result
// transaction on the output channel (out_valid_o / out_ready_i); write, load and
// unknown commands return an all-zero result.
// The table of server slots sits in a synchronous memory with a registered read.
// One command is worked on at a time; in_ready_o is high only when the sequencer
// is idle, and the next command is taken while the previous result still waits.
// A select first scans the table; a weighted pick with a nonzero total weight
// and a round robin pick scan it a second time, and round robin first runs the
// bit-serial remainder. The memory scans read one slot per cycle.
// When the receiver stalls, the result holds in the output register and the
// sequencer waits in its final state before it takes another command.
// Reset clears the present bits of all slots, the rotation counter and the strategy
// register (round robin). The strategy register is written with cfg_we_i.
`default_nettype none

module server_selection_arbiter_core #(
  parameter int unsigned ServerSlots = ssa_pkg::DefaultSlots
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                cfg_we_i,
  input  wire  [ssa_pkg::StratWidth-1:0]     cfg_wdata_i,
  input  wire                                in_valid_i,
  output logic                               in_ready_o,
  input  wire  [ssa_pkg::CmdWidth-1:0]       cmd_i,
  input  wire  [ssa_pkg::SlotWidth-1:0]      slot_i,
  input  wire                                present_i,
  input  wire                                active_i,
  input  wire  [ssa_pkg::WeightWidth-1:0]    weight_i,
  input  wire  [ssa_pkg::LoadWidth-1:0]      load_limit_i,
  input  wire  [ssa_pkg::LoadWidth-1:0]      load_value_i,
  input  wire  [ssa_pkg::RandomWidth-1:0]    random_value_i,
  output logic                               out_valid_o,
  input  wire                                out_ready_i,
  output logic [ssa_pkg::SlotWidth-1:0]      chosen_slot_o,
  output logic                               chosen_valid_o,
  output logic                               used_fallback_o,
  output logic [ssa_pkg::LoadWidth-1:0]      chosen_load_o
);

  localparam int unsigned AddrWidth  = (ServerSlots > 1) ? $clog2(ServerSlots) : 1;
  localparam int unsigned IssueWidth = AddrWidth + 1;
  localparam int unsigned CntWidth   = $clog2(ServerSlots + 1);
  localparam int unsigned TotWidth   = ssa_pkg::WeightWidth + CntWidth;
  localparam int unsigned RndWidth   = ssa_pkg::RandomWidth;
  localparam int unsigned ProdWidth  = RndWidth + TotWidth;
  localparam int unsigned SlotW      = ssa_pkg::SlotWidth;
  localparam int unsigned CtrWidth   = ssa_pkg::CounterWidth;

  localparam logic [3:0] StIdle   = 4'd0;
  localparam logic [3:0] StWr     = 4'd1;
  localparam logic [3:0] StLdRd   = 4'd2;
  localparam logic [3:0] StLdWr   = 4'd3;
  localparam logic [3:0] StScan1  = 4'd4;
  localparam logic [3:0] StDecide = 4'd5;
  localparam logic [3:0] StDiv    = 4'd6;
  localparam logic [3:0] StScan2  = 4'd7;
  localparam logic [3:0] StFetch  = 4'd8;
  localparam logic [3:0] StFetchW = 4'd9;
  localparam logic [3:0] StOut    = 4'd10;

  logic [3:0]                      state_q, state_d;
  logic [ssa_pkg::StratWidth-1:0]  strategy_q;
  logic [CtrWidth-1:0]             rot_q;

  // Captured command.
  logic [SlotW-1:0]                slot_q;
  logic                            present_q;
  logic                            active_q;
  logic [ssa_pkg::WeightWidth-1:0] weight_q;
  logic [ssa_pkg::LoadWidth-1:0]   limit_q;
  logic [ssa_pkg::LoadWidth-1:0]   loadv_q;
  logic [RndWidth-1:0]             rnd_q;

  // Scan sequencing.
  logic [IssueWidth-1:0]           issue_q;
  logic                            pipe_vld_q;
  logic [AddrWidth-1:0]            pipe_idx_q;

  // First-pass summary.
  logic [CntWidth-1:0]             count_q;
  logic [TotWidth-1:0]             total_q;
  logic                            fp_found_q;
  logic [AddrWidth-1:0]            fp_idx_q;
  logic                            fe_found_q;
  logic [AddrWidth-1:0]            fe_idx_q;
  logic [ssa_pkg::LoadWidth-1:0]   min_load_q;
  logic [AddrWidth-1:0]            min_idx_q;

  // Second-pass walk.
  logic [CntWidth-1:0]             k_q;
  logic [TotWidth-1:0]             cum_q;
  logic [TotWidth-1:0]             r_q;
  logic                            found_q;

  // Result being built and the output register.
  logic [AddrWidth-1:0]            pick_q;
  logic                            res_valid_q;
  logic                            res_fb_q;
  logic [ssa_pkg::LoadWidth-1:0]   res_load_q;
  logic                            out_valid_q;
  logic [SlotW-1:0]                out_slot_q;
  logic                            out_cvalid_q;
  logic                            out_fb_q;
  logic [ssa_pkg::LoadWidth-1:0]   out_load_q;

  // Table and remainder unit hookup.
  ssa_pkg::tbl_ctrl_t              tbl_ctrl;
  logic [AddrWidth-1:0]            rd_addr;
  ssa_pkg::slot_entry_t            wr_data;
  ssa_pkg::slot_entry_t            rd_entry;
  logic                            rd_present;
  ssa_pkg::mod_status_t            mod_status;
  logic [CntWidth-1:0]             mod_rem;
  logic                            mod_start;

  logic                            accept;
  logic                            scan_st;
  logic                            issue_go;
  logic                            scan_done;
  logic                            slot_ok;
  logic                            elig;
  logic [TotWidth-1:0]             cum_next;
  logic [ProdWidth-1:0]            prod;
  logic                            out_free;
  logic                            dec_empty;
  logic                            dec_fallback;
  logic                            dec_rr;
  logic                            dec_least;
  logic                            dec_wt;

  assign accept    = in_valid_i && (state_q == StIdle);
  assign scan_st   = (state_q == StScan1) || (state_q == StScan2);
  assign issue_go  = scan_st && (issue_q < IssueWidth'(ServerSlots));
  assign scan_done = scan_st && (issue_q == IssueWidth'(ServerSlots)) && !pipe_vld_q;
  assign slot_ok   = 32'(slot_q) < 32'(ServerSlots);
  assign elig      = rd_present && rd_entry.active && (rd_entry.load < rd_entry.load_limit);
  assign cum_next  = cum_q + TotWidth'(rd_entry.weight);
  assign prod      = ProdWidth'(rnd_q) * ProdWidth'(total_q);
  assign out_free  = !out_valid_q || out_ready_i;

  // How the first-pass summary resolves a select.
  assign dec_empty    = !fp_found_q;
  assign dec_fallback = (count_q == '0);
  assign dec_rr       = (strategy_q == ssa_pkg::StratRoundRobin);
  assign dec_least    = (strategy_q == ssa_pkg::StratLeastLoad);
  assign dec_wt       = (strategy_q == ssa_pkg::StratWeighted) && (total_q != '0);
  assign mod_start    = (state_q == StDecide) && !dec_empty && !dec_fallback && dec_rr;

  // Table access: scans read one slot per cycle, the load command does a
  // read-modify-write, and the final fetch reads the chosen slot's load.
  // Commands are handled one at a time, so a read never overlaps a write.
  always_comb begin
    tbl_ctrl.rd_en      = issue_go || ((state_q == StLdRd) && slot_ok) ||
                          (state_q == StFetch);
    tbl_ctrl.wr_en      = ((state_q == StWr) && slot_ok) ||
                          ((state_q == StLdWr) && slot_ok && rd_present);
    tbl_ctrl.wr_present = (state_q == StWr) ? present_q : 1'b1;
    if (scan_st) begin
      rd_addr = issue_q[AddrWidth-1:0];
    end else if (state_q == StFetch) begin
      rd_addr = pick_q;
    end else begin
      rd_addr = AddrWidth'(slot_q);
    end
    if (state_q == StWr) begin
      wr_data.active     = active_q;
      wr_data.weight     = weight_q;
      wr_data.load_limit = limit_q;
      wr_data.load       = loadv_q;
    end else begin
      wr_data      = rd_entry;
      wr_data.load = loadv_q;
    end
  end

  ssa_table #(
    .Slots     (ServerSlots),
    .AddrWidth (AddrWidth)
  ) u_table (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (tbl_ctrl),
    .rd_addr_i    (rd_addr),
    .wr_addr_i    (AddrWidth'(slot_q)),
    .wr_data_i    (wr_data),
    .rd_data_o    (rd_entry),
    .rd_present_o (rd_present)
  );

  // Round robin needs the rotation counter modulo the eligible count.
  ssa_mod_unit #(
    .DivisorWidth (CntWidth)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (rot_q),
    .divisor_i  (count_q),
    .status_o   (mod_status),
    .rem_o      (mod_rem)
  );

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          unique case (cmd_i)
            ssa_pkg::CmdSelect: state_d = StScan1;
            ssa_pkg::CmdWrite:  state_d = StWr;
            ssa_pkg::CmdLoad:   state_d = StLdRd;
            default:            state_d = StOut;
          endcase
        end
      end
      StWr:   state_d = StOut;
      StLdRd: state_d = StLdWr;
      StLdWr: state_d = StOut;
      StScan1: begin
        if (scan_done) begin
          state_d = StDecide;
        end
      end
      StDecide: begin
        if (dec_empty) begin
          state_d = StOut;
        end else if (dec_fallback) begin
          state_d = StFetch;
        end else if (dec_rr) begin
          state_d = StDiv;
        end else if (dec_wt) begin
          state_d = StScan2;
        end else begin
          state_d = StFetch;
        end
      end
      StDiv: begin
        if (mod_status.done) begin
          state_d = StScan2;
        end
      end
      StScan2: begin
        if (scan_done) begin
          state_d = StFetch;
        end
      end
      StFetch:  state_d = StFetchW;
      StFetchW: state_d = StOut;
      StOut: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      strategy_q  <= ssa_pkg::StratRoundRobin;
      rot_q       <= '0;
      pipe_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      pipe_vld_q <= issue_go;
      if (cfg_we_i) begin
        strategy_q <= cfg_wdata_i;
      end
      // The counter moves only when round robin actually picks.
      if (mod_start) begin
        rot_q <= rot_q + 1'b1;
      end
      if ((state_q == StOut) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Running total of eligible weights.
  function automatic logic [TotWidth-1:0] cum_next_total(
    input logic [TotWidth-1:0]             acc,
    input logic [ssa_pkg::WeightWidth-1:0] w
  );
    cum_next_total = acc + TotWidth'(w);
  endfunction

  always_ff @(posedge clk_i) begin
    if (accept) begin
      slot_q      <= slot_i;
      present_q   <= present_i;
      active_q    <= active_i;
      weight_q    <= weight_i;
      limit_q     <= load_limit_i;
      loadv_q     <= load_value_i;
      rnd_q       <= random_value_i;
      issue_q     <= '0;
      count_q     <= '0;
      total_q     <= '0;
      fp_found_q  <= 1'b0;
      fe_found_q  <= 1'b0;
      res_valid_q <= 1'b0;
      res_fb_q    <= 1'b0;
      res_load_q  <= '0;
      pick_q      <= '0;
    end

    if (issue_go) begin
      issue_q    <= issue_q + 1'b1;
      pipe_idx_q <= issue_q[AddrWidth-1:0];
    end

    // First pass: present and eligible summary, count, total weight, minimum load.
    if ((state_q == StScan1) && pipe_vld_q) begin
      if (rd_present && !fp_found_q) begin
        fp_found_q <= 1'b1;
        fp_idx_q   <= pipe_idx_q;
      end
      if (elig) begin
        count_q <= count_q + 1'b1;
        total_q <= cum_next_total(total_q, rd_entry.weight);
        if (!fe_found_q) begin
          fe_found_q <= 1'b1;
          fe_idx_q   <= pipe_idx_q;
          min_load_q <= rd_entry.load;
          min_idx_q  <= pipe_idx_q;
        end else if (rd_entry.load < min_load_q) begin
          min_load_q <= rd_entry.load;
          min_idx_q  <= pipe_idx_q;
        end
      end
    end

    if (state_q == StDecide) begin
      k_q     <= '0;
      cum_q   <= '0;
      found_q <= 1'b0;
      issue_q <= '0;
      r_q     <= prod[ProdWidth-1:RndWidth];
      if (!dec_empty) begin
        res_valid_q <= 1'b1;
        if (dec_fallback) begin
          pick_q   <= fp_idx_q;
          res_fb_q <= 1'b1;
        end else if (dec_least) begin
          pick_q <= min_idx_q;
        end else begin
          pick_q <= fe_idx_q;
        end
      end
    end

    // Second pass: walk the eligible slots toward the target entry or weight.
    if ((state_q == StScan2) && pipe_vld_q && elig) begin
      k_q   <= k_q + 1'b1;
      cum_q <= cum_next;
      if (!found_q) begin
        if (dec_rr ? (k_q == mod_rem) : (r_q < cum_next)) begin
          found_q <= 1'b1;
          pick_q  <= pipe_idx_q;
        end
      end
    end

    if (state_q == StFetchW) begin
      res_load_q <= rd_entry.load;
    end

    if ((state_q == StOut) && out_free) begin
      out_slot_q   <= SlotW'(pick_q);
      out_cvalid_q <= res_valid_q;
      out_fb_q     <= res_fb_q;
      out_load_q   <= res_load_q;
    end
  end

  assign in_ready_o      = (state_q == StIdle);
  assign out_valid_o     = out_valid_q;
  assign chosen_slot_o   = out_slot_q;
  assign chosen_valid_o  = out_cvalid_q;
  assign used_fallback_o = out_fb_q;
  assign chosen_load_o   = out_load_q;

`ifndef SYNTHESIS
  // A result without a chosen server carries all-zero fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !chosen_valid_o) |->
      (chosen_slot_o == '0) && !used_fallback_o && (chosen_load_o == '0))
    else $error("invalid result carries nonzero fields");

  // A fallback pick always names a present server.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && used_fallback_o) |-> chosen_valid_o)
    else $error("fallback flagged without a valid pick");

  // Only one command is in work at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second command taken while one is in work");

  // The rotation counter only ever steps by one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rot_q != $past(rot_q)) |-> (rot_q == $past(rot_q) + 32'd1))
    else $error("rotation counter jumped");

  // The remainder unit is only started from an idle state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_start |-> !mod_status.busy)
    else $error("remainder unit restarted while busy");
`endif

endmodule

`default_nettype wire

@@ verif/tb.sv @@
`default_nettype none

// Self-checking bench for the server selection arbiter.
// A queue of pending command transactions is filled phase by phase from the
// initial block. A clocked driver offers them on the input channel, and a
// clocked monitor takes result transactions from the output channel. The bench
// keeps its own copy of the server slots, the rotation counter and the
// strategy. At every accepted command it works out the result that the block
// must return, and the monitor compares each result with the oldest one
// still waiting.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Slots        = ssa_pkg::DefaultSlots;
  localparam int unsigned CmdWidth     = ssa_pkg::CmdWidth;
  localparam int unsigned SlotWidth    = ssa_pkg::SlotWidth;
  localparam int unsigned WeightWidth  = ssa_pkg::WeightWidth;
  localparam int unsigned LoadWidth    = ssa_pkg::LoadWidth;
  localparam int unsigned RandomWidth  = ssa_pkg::RandomWidth;
  localparam int unsigned StratWidth   = ssa_pkg::StratWidth;
  localparam int unsigned CounterWidth = ssa_pkg::CounterWidth;

  // The fourth command code has no meaning; the block must return all zeros.
  localparam logic [CmdWidth-1:0] CmdIgnored = 2'd3;

  typedef struct packed {
    logic [CmdWidth-1:0]    cmd;
    logic [SlotWidth-1:0]   slot;
    logic                   present;
    logic                   active;
    logic [WeightWidth-1:0] weight;
    logic [LoadWidth-1:0]   limit;
    logic [LoadWidth-1:0]   load;
    logic [RandomWidth-1:0] rnd;
  } lb_cmd_t;

  typedef struct packed {
    logic [SlotWidth-1:0] slot;
    logic                 valid;
    logic                 fallback;
    logic [LoadWidth-1:0] load;
  } pick_t;

  logic clk;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [StratWidth-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  lb_cmd_t bus = '0;
  logic out_ready = 1'b0;

  wire                   in_ready;
  wire                   out_valid;
  wire [SlotWidth-1:0]   chosen_slot;
  wire                   chosen_valid;
  wire                   used_fallback;
  wire [LoadWidth-1:0]   chosen_load;

  // Shadow copy of the block's state.
  logic                   srv_present [Slots];
  logic                   srv_active  [Slots];
  logic [WeightWidth-1:0] srv_weight  [Slots];
  logic [LoadWidth-1:0]   srv_limit   [Slots];
  logic [LoadWidth-1:0]   srv_load    [Slots];
  logic [CounterWidth-1:0] rr_count;
  logic [StratWidth-1:0]  strat_now;

  lb_cmd_t cmds_todo [$];
  pick_t   picks_due [$];
  lb_cmd_t cur_cmd;

  int unsigned src_gap = 0;
  int unsigned src_calm = 0;
  int unsigned snk_gap = 0;
  int unsigned snk_calm = 0;
  int unsigned hold_left = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  logic        backlog_done = 1'b0;
  logic        quiet_tail = 1'b0;

  logic [StratWidth-1:0] phase_plan [8];

  server_selection_arbiter_core i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .cmd_i           (bus.cmd),
    .slot_i          (bus.slot),
    .present_i       (bus.present),
    .active_i        (bus.active),
    .weight_i        (bus.weight),
    .load_limit_i    (bus.limit),
    .load_value_i    (bus.load),
    .random_value_i  (bus.rnd),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .chosen_slot_o   (chosen_slot),
    .chosen_valid_o  (chosen_valid),
    .used_fallback_o (used_fallback),
    .chosen_load_o   (chosen_load)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Applies one command to the shadow state and returns the result it causes.
  // Write, load and unknown commands all return an all-zero result.
  function automatic pick_t arbitrate(lb_cmd_t c);
    pick_t r;
    logic elig [Slots];
    int unsigned n_elig;
    int first_pres;
    int first_elig;
    int pick;
    int unsigned k;
    logic [31:0] total;
    logic [31:0] cum;
    logic [31:0] target;
    logic [31:0] thresh;
    logic [63:0] prod;
    r = '0;
    case (c.cmd)
      ssa_pkg::CmdWrite: begin
        if (c.slot < Slots) begin
          // Clearing a slot wipes every field, not just the present bit.
          srv_present[c.slot] = c.present;
          srv_active[c.slot]  = c.present ? c.active : 1'b0;
          srv_weight[c.slot]  = c.present ? c.weight : '0;
          srv_limit[c.slot]   = c.present ? c.limit : '0;
          srv_load[c.slot]    = c.present ? c.load : '0;
        end
      end
      ssa_pkg::CmdLoad: begin
        if (c.slot < Slots && srv_present[c.slot]) srv_load[c.slot] = c.load;
      end
      ssa_pkg::CmdSelect: begin
        n_elig = 0;
        first_pres = -1;
        first_elig = -1;
        pick = -1;
        total = '0;
        for (int i = 0; i < Slots; i++) begin
          elig[i] = srv_present[i] && srv_active[i] && (srv_load[i] < srv_limit[i]);
          if (srv_present[i] && first_pres < 0) first_pres = i;
          if (elig[i]) begin
            if (first_elig < 0) first_elig = i;
            n_elig++;
            total += 32'(srv_weight[i]);
          end
        end
        if (first_pres >= 0) begin
          if (n_elig == 0) begin
            // Nothing eligible: hand out the first present slot, counter untouched.
            pick = first_pres;
            r.fallback = 1'b1;
          end else begin
            case (strat_now)
              ssa_pkg::StratRoundRobin: begin
                target = rr_count % n_elig;
                k = 0;
                for (int i = 0; i < Slots; i++) begin
                  if (elig[i] && pick < 0) begin
                    if (k == target) pick = i;
                    k++;
                  end
                end
                rr_count++;
              end
              ssa_pkg::StratLeastLoad: begin
                for (int i = 0; i < Slots; i++) begin
                  if (elig[i] && (pick < 0 || srv_load[i] < srv_load[pick])) pick = i;
                end
              end
              ssa_pkg::StratWeighted: begin
                // A zero total weight leaves pick unset, so the first eligible wins.
                if (total != 0) begin
                  prod = 64'(c.rnd) * 64'(total);
                  thresh = prod[47:16];
                  cum = '0;
                  for (int i = 0; i < Slots; i++) begin
                    if (elig[i] && pick < 0) begin
                      cum += 32'(srv_weight[i]);
                      if (thresh < cum) pick = i;
                    end
                  end
                end
              end
              default: ;
            endcase
            if (pick < 0) pick = first_elig;
          end
          r.slot  = SlotWidth'(pick);
          r.valid = 1'b1;
          r.load  = srv_load[pick];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic lb_cmd_t mk(logic [CmdWidth-1:0] cmd, logic [SlotWidth-1:0] slot,
                                 logic present, logic active,
                                 logic [WeightWidth-1:0] weight, logic [LoadWidth-1:0] limit,
                                 logic [LoadWidth-1:0] load, logic [RandomWidth-1:0] rnd);
    lb_cmd_t c;
    c = '{cmd, slot, present, active, weight, limit, load, rnd};
    return c;
  endfunction

  // Random commands keep the table mostly populated with small limits and
  // loads, so that eligibility changes often and every strategy has a choice.
  function automatic lb_cmd_t rand_cmd();
    lb_cmd_t c;
    int unsigned roll;
    roll      = $urandom_range(0, 99);
    c.slot    = SlotWidth'($urandom_range(0, Slots - 1));
    c.present = 1'($urandom_range(0, 1));
    c.active  = 1'($urandom_range(0, 1));
    c.weight  = WeightWidth'($urandom_range(0, 65535));
    c.limit   = LoadWidth'($urandom_range(0, 65535));
    c.load    = LoadWidth'($urandom_range(0, 65535));
    c.rnd     = RandomWidth'($urandom_range(0, 65535));
    if (roll < 42) begin
      c.cmd = ssa_pkg::CmdSelect;
      case ($urandom_range(0, 9))
        0: c.rnd = '0;
        1: c.rnd = '1;
        default: ;
      endcase
    end else if (roll < 64) begin
      c.cmd     = ssa_pkg::CmdWrite;
      c.present = ($urandom_range(0, 7) != 0);
      c.active  = ($urandom_range(0, 5) != 0);
      case ($urandom_range(0, 7))
        0: c.weight = '0;
        1: c.weight = '1;
        2, 3, 4: c.weight = WeightWidth'($urandom_range(1, 20));
        default: ;
      endcase
      case ($urandom_range(0, 7))
        0: c.limit = '1;
        1: c.limit = '0;
        2: ;
        default: c.limit = LoadWidth'($urandom_range(1, 24));
      endcase
      if ($urandom_range(0, 7) != 0) c.load = LoadWidth'($urandom_range(0, c.limit));
    end else if (roll < 94) begin
      c.cmd = ssa_pkg::CmdLoad;
      case ($urandom_range(0, 9))
        0: c.load = '1;
        1: ;
        default: c.load = LoadWidth'($urandom_range(0, 24));
      endcase
    end else begin
      c.cmd = CmdIgnored;
    end
    return c;
  endfunction

  // Length of the next idle burst, or zero. Calm stretches of no idling are
  // mixed in, and the last phase of the run has no idling at all.
  function automatic int unsigned burst_len(inout int unsigned calm_left,
                                            input int unsigned pct);
    if (quiet_tail) return 0;
    if (calm_left != 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      calm_left = $urandom_range(20, 60);
      return 0;
    end
    if ($urandom_range(0, 99) < pct) return $urandom_range(1, 7);
    return 0;
  endfunction

  // Driver: the prediction is made at the edge where a command is accepted,
  // so the shadow state advances in the same order as the block's.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        picks_due.push_back(arbitrate(cur_cmd));
        src_gap = burst_len(src_calm, 30);
      end
      if (!in_valid || in_ready) begin
        if (src_gap != 0) begin
          src_gap--;
          in_valid <= 1'b0;
        end else if (cmds_todo.size() != 0) begin
          cur_cmd = cmds_todo.pop_front();
          bus <= cur_cmd;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Once, early in the run, the receiver holds off for a long stretch so that
  // the block's output register fills and the input channel stalls behind it.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!backlog_done && results_seen >= 300) begin
      backlog_done <= 1'b1;
      hold_left <= 400;
    end
  end

  // Monitor: checks every result transaction and drives out_ready.
  always @(posedge clk) begin
    pick_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (picks_due.size() == 0) begin
          $display("%0t: result with nothing expected: slot %0d valid %0b fallback %0b load %0d",
                   $time, chosen_slot, chosen_valid, used_fallback, chosen_load);
          mismatches++;
        end else begin
          want = picks_due.pop_front();
          if (chosen_slot !== want.slot) begin
            $display("%0t: chosen_slot expected %0d actual %0d", $time, want.slot, chosen_slot);
            mismatches++;
          end
          if (chosen_valid !== want.valid) begin
            $display("%0t: chosen_valid expected %0b actual %0b", $time, want.valid,
                     chosen_valid);
            mismatches++;
          end
          if (used_fallback !== want.fallback) begin
            $display("%0t: used_fallback expected %0b actual %0b", $time, want.fallback,
                     used_fallback);
            mismatches++;
          end
          if (chosen_load !== want.load) begin
            $display("%0t: chosen_load expected %0d actual %0d", $time, want.load, chosen_load);
            mismatches++;
          end
        end
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
      end else if (snk_gap != 0) begin
        snk_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        snk_gap = burst_len(snk_calm, 8);
      end
    end
  end

  // Waits until every queued command has been accepted and every result has
  // come back. Every command causes a result, so the block is idle after that.
  task automatic drain();
    do @(negedge clk);
    while (cmds_todo.size() != 0 || in_valid || picks_due.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // Writes the strategy register while the block is idle.
  task automatic set_strategy(logic [StratWidth-1:0] s);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= s;
    strat_now = s;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    #8_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    for (int i = 0; i < Slots; i++) begin
      srv_present[i] = 1'b0;
      srv_active[i]  = 1'b0;
      srv_weight[i]  = '0;
      srv_limit[i]   = '0;
      srv_load[i]    = '0;
    end
    rr_count = '0;
    strat_now = ssa_pkg::StratRoundRobin;
    phase_plan = '{ssa_pkg::StratRoundRobin, ssa_pkg::StratLeastLoad,
                   ssa_pkg::StratWeighted, ssa_pkg::StratFirst,
                   ssa_pkg::StratWeighted, ssa_pkg::StratRoundRobin,
                   ssa_pkg::StratLeastLoad, ssa_pkg::StratWeighted};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Under the reset strategy: empty table, unknown command, a lone eligible
    // slot, a load equal to its limit, a load on an absent slot and clears.
    cmds_todo.push_back(mk(ssa_pkg::CmdSelect, 0, 0, 0, '0, '0, '0, '0));
    cmds_todo.push_back(mk(CmdIgnored, 7, 1, 1, '1, '1, '1, '1));
    cmds_todo.push_back(mk(ssa_pkg::CmdWrite, 7, 1, 1, '1, '1, '0, '0));
    cmds_todo.push_back(mk(ssa_pkg::CmdWrite, 0, 1, 0, '0, '0, '1, '0));
    cmds_todo.push_back(mk(ssa_pkg::CmdSelect, 0, 0, 0, '0, '0, '0, '1));
    cmds_todo.push_back(mk(ssa_pkg::CmdLoad, 7, 0, 0, '0, '0, '1, '0));
    cmds_todo.push_back(mk(ssa_pkg::CmdSelect, 0, 0, 0, '0, '0, '0, '0));
    cmds_todo.push_back(mk(ssa_pkg::CmdLoad, 3, 0, 0, '0, '0, 16'd5, '0));
    cmds_todo.push_back(mk(ssa_pkg::CmdWrite, 0, 0, 1, '1, '1, '1, '0));
    cmds_todo.push_back(mk(ssa_pkg::CmdSelect, 0, 0, 0, '0, '0, '0, '0));
    cmds_todo.push_back(mk(ssa_pkg::CmdWrite, 7, 0, 0, '0, '0, '0, '0));
    cmds_todo.push_back(mk(ssa_pkg::CmdSelect, 0, 0, 0, '0, '0, '0, '0));
    drain();

    // Weighted: zero total weight, then the extremes of the random word,
    // including a threshold that lands exactly on a cumulative boundary.
    set_strategy(ssa_pkg::StratWeighted);
    cmds_todo.push_back(mk(ssa_pkg::CmdWrite, 1, 1, 1, '0, 16'd10, '0, '0));
    cmds_todo.push_back(mk(ssa_pkg::CmdWrite, 2, 1, 1, '0, 16'd10, 16'd3, '0));
    cmds_todo.push_back(mk(ssa_pkg::CmdSelect, 0, 0, 0, '0, '0, '0, '1));
    cmds_todo.push_back(mk(ssa_pkg::CmdWrite, 2, 1, 1, '1, 16'd10, 16'd3, '0));
    cmds_todo.push_back(mk(ssa_pkg::CmdSelect, 0, 0, 0, '0, '0, '0, '0));
    cmds_todo.push_back(mk(ssa_pkg::CmdSelect, 0, 0, 0, '0, '0, '0, '1));
    cmds_todo.push_back(mk(ssa_pkg::CmdWrite, 5, 1, 1, 16'd1, 16'd1, '0, '0));
    cmds_todo.push_back(mk(ssa_pkg::CmdSelect, 0, 0, 0, '0, '0, '0, '0));
    cmds_todo.push_back(mk(ssa_pkg::CmdSelect, 0, 0, 0, '0, '0, '0, '1));
    drain();

    // Least load with a tie: the lower slot must win.
    set_strategy(ssa_pkg::StratLeastLoad);
    cmds_todo.push_back(mk(ssa_pkg::CmdLoad, 2, 0, 0, '0, '0, '0, '0));
    cmds_todo.push_back(mk(ssa_pkg::CmdSelect, 0, 0, 0, '0, '0, '0, '0));
    drain();

    set_strategy(ssa_pkg::StratRoundRobin);
    cmds_todo.push_back(mk(ssa_pkg::CmdSelect, 0, 0, 0, '0, '0, '0, '0));
    cmds_todo.push_back(mk(ssa_pkg::CmdSelect, 0, 0, 0, '0, '0, '0, '0));
    drain();

    // Random phases, one per planned strategy; the last runs with no idling.
    for (int p = 0; p < 8; p++) begin
      set_strategy(phase_plan[p]);
      if (p == 7) quiet_tail = 1'b1;
      repeat (230) cmds_todo.push_back(rand_cmd());
      drain();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0 && picks_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
